/* src/i2cm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int unsigned CYCLES_PER_UNIT_DEF = 48;
    localparam int unsigned BITS_PER_BYTE       = 8;
    localparam logic [7:0]  DELAY_RESET         = 8'd5;

    // Request codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_STOP  = 2'd3
    } t_req;

    // Sequencer states: apart from idle, each is one segment of a request's phase run.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_WBIT,
        ST_WACK,
        ST_RBIT,
        ST_RGAP,
        ST_RACK,
        ST_RLAST,
        ST_STOP
    } t_state;

    // Last sub-phase index of each segment.
    localparam logic [1:0] SUB_LAST_START = 2'd2;
    localparam logic [1:0] SUB_LAST_BIT   = 2'd3;
    localparam logic [1:0] SUB_LAST_STOP  = 2'd3;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       smp;
        logic       last;
        logic       ack;
        logic [7:0] rdata;
    } t_phase;

    typedef struct packed {
        logic busy;
        logic done;
    } t_tmr_stat;

endpackage

`default_nettype wire

/* src/i2cm_phase_gen.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cm_phase_gen (
    input  var i2cm_pkg::t_state i_state,
    input  var logic [1:0]       i_sub,
    input  var logic             i_scl_level,
    input  var logic             i_data_msb,
    input  var logic             i_send_ack,
    input  var logic             i_ack_in,
    input  var logic [7:0]       i_rdata,
    output i2cm_pkg::t_phase     o_phase
);
    import i2cm_pkg::*;

    logic w_bit;

    always_comb begin
        o_phase = '0;
        // Data bit driven in a write slot; in the read acknowledge slot the
        // master drives low for ACK and releases for NACK.
        w_bit = (i_state == ST_RACK) ? ~i_send_ack : i_data_msb;
        case (i_state)
            ST_START: begin
                case (i_sub)
                    2'd0:    begin o_phase.scl = 1'b1; o_phase.sda = 1'b1; end
                    2'd1:    begin o_phase.scl = 1'b1; o_phase.sda = 1'b0; end
                    default: begin o_phase.scl = 1'b0; o_phase.sda = 1'b0; end
                endcase
            end
            ST_WBIT, ST_RACK: begin
                case (i_sub)
                    2'd0:    begin o_phase.scl = i_scl_level; o_phase.sda = w_bit; end
                    2'd1:    begin o_phase.scl = 1'b1;        o_phase.sda = w_bit; end
                    2'd2:    begin o_phase.scl = 1'b0;        o_phase.sda = w_bit; end
                    default: begin o_phase.scl = 1'b0;        o_phase.sda = 1'b0;  end
                endcase
            end
            ST_WACK, ST_RBIT: begin
                o_phase.sda = 1'b1;
                case (i_sub)
                    2'd0:    o_phase.scl = i_scl_level;
                    2'd1:    o_phase.scl = 1'b1;
                    2'd2:    begin o_phase.scl = 1'b1; o_phase.smp = 1'b1; end
                    default: o_phase.scl = 1'b0;
                endcase
                if ((i_state == ST_WACK) && (i_sub == SUB_LAST_BIT)) begin
                    o_phase.last = 1'b1;
                    o_phase.ack  = i_ack_in;
                end
            end
            ST_RGAP: begin
                o_phase.scl = i_scl_level;
                o_phase.sda = 1'b1;
            end
            ST_RLAST: begin
                o_phase.scl   = i_scl_level;
                o_phase.sda   = 1'b0;
                o_phase.last  = 1'b1;
                o_phase.rdata = i_rdata;
            end
            ST_STOP: begin
                case (i_sub)
                    2'd0:    begin o_phase.scl = i_scl_level; o_phase.sda = 1'b0; end
                    2'd1:    begin o_phase.scl = 1'b0;        o_phase.sda = 1'b0; end
                    2'd2:    begin o_phase.scl = 1'b1;        o_phase.sda = 1'b0; end
                    default: begin
                        o_phase.scl  = 1'b1;
                        o_phase.sda  = 1'b1;
                        o_phase.last = 1'b1;
                    end
                endcase
            end
            default: o_phase = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/i2cm_hold_timer.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cm_hold_timer #(
    parameter int unsigned CYCLES_PER_UNIT = i2cm_pkg::CYCLES_PER_UNIT_DEF
) (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_start,
    input  var logic [7:0]    i_units,
    output i2cm_pkg::t_tmr_stat o_stat
);
    import i2cm_pkg::*;

    localparam int unsigned CW = (CYCLES_PER_UNIT > 1) ? $clog2(CYCLES_PER_UNIT) : 1;
    localparam logic [CW-1:0] CYC_LAST = CW'(CYCLES_PER_UNIT - 1);

    logic          r_active, n_active;
    logic [7:0]    r_units,  n_units;
    logic [CW-1:0] r_cyc,    n_cyc;

    always_comb begin
        n_active = r_active;
        n_units  = r_units;
        n_cyc    = r_cyc;
        if (i_start) begin
            n_active = 1'b1;
            n_units  = i_units;
            n_cyc    = '0;
        end else if (r_active) begin
            if (r_units == 8'd0) begin
                n_active = 1'b0;
            end else if (r_cyc == CYC_LAST) begin
                n_cyc   = '0;
                n_units = r_units - 8'd1;
            end else begin
                n_cyc = r_cyc + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_units  <= '0;
            r_cyc    <= '0;
        end else begin
            r_active <= n_active;
            r_units  <= n_units;
            r_cyc    <= n_cyc;
        end
    end

    assign o_stat.busy = r_active;
    assign o_stat.done = r_active && (r_units == 8'd0);

endmodule

`default_nettype wire

/* src/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Single-master I2C byte engine. Each request (start plus address, write
// byte, read byte, stop) is expanded into a run of line phases: 39 for start,
// 36 for write, 38 for read and 4 for stop. Each phase is offered on the
// output channel and, once taken, the lines are held by a shared hold timer
// for the number of delay units last written through the config port; the
// hold timer, together with back-pressure on the output, sets the pace of
// the phases. One request is handled at a time, and the input is stalled
// until the last phase of the current one has been held.
module i2c_master_byte_engine #(
    parameter int unsigned CYCLES_PER_UNIT = i2cm_pkg::CYCLES_PER_UNIT_DEF
) (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_cfg_we,
    input  var logic [7:0] i_cfg_data,
    input  var logic       i_in_valid,
    output logic           o_in_stall,
    input  var logic [1:0] i_req_type,
    input  var logic [7:0] i_data_byte,
    input  var logic       i_send_ack,
    input  var logic [7:0] i_bus_sda_bits,
    input  var logic       i_bus_sda_ack,
    output logic           o_out_valid,
    input  var logic       i_out_stall,
    output logic           o_scl_release,
    output logic           o_sda_release,
    output logic           o_sample_now,
    output logic           o_phase_last,
    output logic           o_ack_bit,
    output logic [7:0]     o_read_byte
);
    import i2cm_pkg::*;

    localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);

    t_state     r_state, n_state;
    logic [1:0] r_sub,   n_sub;
    logic [2:0] r_bit,   n_bit;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_shift, n_shift;
    logic       r_send_ack, r_ack_in;
    logic       r_scl_level;
    logic [7:0] r_delay;

    t_phase     w_phase;
    t_tmr_stat  w_tmr;
    logic       w_in_fire;
    logic       w_out_fire;

    i2cm_phase_gen u_phase_gen (
        .i_state     (r_state),
        .i_sub       (r_sub),
        .i_scl_level (r_scl_level),
        .i_data_msb  (r_shift[7]),
        .i_send_ack  (r_send_ack),
        .i_ack_in    (r_ack_in),
        .i_rdata     (r_shift),
        .o_phase     (w_phase)
    );

    i2cm_hold_timer #(
        .CYCLES_PER_UNIT (CYCLES_PER_UNIT)
    ) u_hold_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_out_fire),
        .i_units (r_delay),
        .o_stat  (w_tmr)
    );

    // Handshake outputs.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_ovalid;
        w_in_fire   = i_in_valid && (r_state == ST_IDLE);
        w_out_fire  = r_ovalid && !i_out_stall;
    end

    // Next state: the sequencer advances one phase each time the hold ends.
    always_comb begin
        n_state  = r_state;
        n_sub    = r_sub;
        n_bit    = r_bit;
        n_ovalid = r_ovalid;
        n_shift  = r_shift;
        if (w_out_fire) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_sub    = '0;
                    n_bit    = '0;
                    n_ovalid = 1'b1;
                    n_shift  = i_data_byte;
                    case (t_req'(i_req_type))
                        REQ_START: n_state = ST_START;
                        REQ_WRITE: n_state = ST_WBIT;
                        REQ_READ: begin
                            n_state = ST_RBIT;
                            n_shift = i_bus_sda_bits;
                        end
                        REQ_STOP:  n_state = ST_STOP;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            default: begin
                if (w_tmr.done) begin
                    n_ovalid = 1'b1;
                    n_sub    = r_sub + 2'd1;
                    case (r_state)
                        ST_START: begin
                            if (r_sub == SUB_LAST_START) begin
                                n_state = ST_WBIT;
                                n_sub   = '0;
                            end
                        end
                        ST_WBIT: begin
                            if (r_sub == SUB_LAST_BIT) begin
                                n_shift = {r_shift[6:0], 1'b0};
                                if (r_bit == BIT_LAST) begin
                                    n_state = ST_WACK;
                                end else begin
                                    n_bit = r_bit + 3'd1;
                                end
                            end
                        end
                        ST_RBIT: begin
                            if ((r_sub == SUB_LAST_BIT) && (r_bit == BIT_LAST)) begin
                                n_state = ST_RGAP;
                            end else if (r_sub == SUB_LAST_BIT) begin
                                n_bit = r_bit + 3'd1;
                            end
                        end
                        ST_RGAP: begin
                            n_state = ST_RACK;
                            n_sub   = '0;
                        end
                        ST_RACK: begin
                            if (r_sub == SUB_LAST_BIT) begin
                                n_state = ST_RLAST;
                            end
                        end
                        default: begin
                            // A segment that ends the request returns to idle
                            // on its final phase.
                            if (w_phase.last) begin
                                n_state  = ST_IDLE;
                                n_ovalid = 1'b0;
                                n_sub    = '0;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sub       <= '0;
            r_bit       <= '0;
            r_ovalid    <= 1'b0;
            r_shift     <= '0;
            r_scl_level <= 1'b1;
            r_delay     <= DELAY_RESET;
        end else begin
            r_state  <= n_state;
            r_sub    <= n_sub;
            r_bit    <= n_bit;
            r_ovalid <= n_ovalid;
            r_shift  <= n_shift;
            if (w_out_fire) begin
                r_scl_level <= w_phase.scl;
            end
            if (i_cfg_we) begin
                r_delay <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_send_ack <= i_send_ack;
            r_ack_in   <= i_bus_sda_ack;
        end
    end

    assign o_scl_release = w_phase.scl;
    assign o_sda_release = w_phase.sda;
    assign o_sample_now  = w_phase.smp;
    assign o_phase_last  = w_phase.last;
    assign o_ack_bit     = w_phase.ack;
    assign o_read_byte   = w_phase.rdata;

`ifndef SYNTHESIS
    a_idle_no_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_out_valid)
        else $error("phase offered while idle");

    a_phase_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |=> (!o_out_valid && w_tmr.busy))
        else $error("accepted phase not followed by a hold");

    a_no_offer_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ovalid && w_tmr.busy))
        else $error("phase offered during a hold");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tmr.done && w_phase.last) |=> (r_state == ST_IDLE))
        else $error("request did not end after its last phase");
`endif

endmodule

`default_nettype wire
